FILE: hdl/bracket_balance_checker_defines.svh
// Assertion macros for the port assertions of the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bbc_pkg.sv
// Types, constants and the character decoder of the bracket balance checker.
package bbc_pkg;

   localparam int unsigned BBC_DEPTH = 64;

   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_NONE   = 2'd0;
   localparam kind_type KIND_ROUND  = 2'd1;
   localparam kind_type KIND_SQUARE = 2'd2;
   localparam kind_type KIND_CURLY  = 2'd3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       no_char;
      logic       last;
   } req_type;

   typedef struct packed {
      logic balanced;
      logic overflowed;
   } rsp_type;

   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } decode_type;

   // one word in flight between the tracking stage and the resolve stage
   typedef struct packed {
      logic     pop_check;
      kind_type kind;
      logic     last;
      logic     overflow;
      logic     error;
      logic     level_zero;
      logic     any_char;
   } stage_type;

   function automatic decode_type decode_char(input logic [7:0] c);
      decode_type d;
      d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_NONE};
      case (c)
         CHAR_ROUND_OPEN:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
         CHAR_SQUARE_OPEN:  d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
         CHAR_CURLY_OPEN:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
         CHAR_ROUND_CLOSE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
         CHAR_SQUARE_CLOSE: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
         CHAR_CURLY_CLOSE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
         default:           d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_NONE};
      endcase
      return d;
   endfunction

endpackage

FILE: hdl/bbc_stack_ram.sv
// Bracket stack storage: one write port, one read port with registered data.
module bbc_stack_ram #(
   parameter int unsigned DEPTH = bbc_pkg::BBC_DEPTH,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  bbc_pkg::kind_type  wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output bbc_pkg::kind_type  rd_data
);

   bbc_pkg::kind_type mem_ff [DEPTH];
   bbc_pkg::kind_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read while no new read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bbc_track.sv
// Front stage: decode the word, move the stack level, push and issue top reads.
module bbc_track #(
   parameter int unsigned DEPTH = bbc_pkg::BBC_DEPTH,
   localparam int unsigned ADDR_W = $clog2(DEPTH),
   localparam int unsigned LEVEL_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue,
   input  bbc_pkg::req_type    req_data,
   input  logic                string_err,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output bbc_pkg::kind_type   wr_data,
   output logic                rd_en,
   output logic [ADDR_W-1:0]   rd_addr,
   output bbc_pkg::stage_type  stage_word
);

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(DEPTH);

   logic [LEVEL_W-1:0] level_ff, level_in, level_nx, level_dec;
   logic               err_ff, err_in, err_nx;
   logic               ovf_ff, ovf_in, ovf_nx;
   logic               any_ff, any_in, any_nx;
   bbc_pkg::decode_type dec;
   logic               has_char, halted, do_push, do_pop, full, empty;

   always_comb begin
      dec       = bbc_pkg::decode_char(req_data.char_code);
      has_char  = !req_data.no_char;
      halted    = err_ff | string_err;
      do_push   = issue & has_char & !halted & dec.is_open;
      do_pop    = issue & has_char & !halted & dec.is_close;
      full      = (level_ff == LEVEL_FULL);
      empty     = (level_ff == '0);
      level_dec = level_ff - 1'b1;

      level_nx = level_ff;
      err_nx   = err_ff;
      ovf_nx   = ovf_ff;
      any_nx   = any_ff | has_char;

      if (do_push) begin
         if (full) begin
            ovf_nx = 1'b1;
            err_nx = 1'b1;
         end else begin
            level_nx = level_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (empty) begin
            err_nx = 1'b1;
         end else begin
            level_nx = level_dec;
         end
      end

      wr_en   = do_push & !full;
      wr_addr = level_ff[ADDR_W-1:0];
      wr_data = dec.kind;
      rd_en   = do_pop & !empty;
      rd_addr = level_dec[ADDR_W-1:0];

      stage_word = '{pop_check:  do_pop & !empty,
                     kind:       dec.kind,
                     last:       req_data.last,
                     overflow:   ovf_nx,
                     error:      err_nx,
                     level_zero: (level_nx == '0),
                     any_char:   any_nx};

      // clear the string state once the last word is taken
      level_in = level_ff;
      err_in   = err_ff;
      ovf_in   = ovf_ff;
      any_in   = any_ff;
      if (issue) begin
         if (req_data.last) begin
            level_in = '0;
            err_in   = 1'b0;
            ovf_in   = 1'b0;
            any_in   = 1'b0;
         end else begin
            level_in = level_nx;
            err_in   = err_nx;
            ovf_in   = ovf_nx;
            any_in   = any_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         err_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         level_ff <= level_in;
         err_ff   <= err_in;
         ovf_ff   <= ovf_in;
         any_ff   <= any_in;
      end
   end

endmodule

FILE: hdl/bbc_resolve.sv
// Back stage: compare the stack top, keep the mismatch flag, hold the result.
module bbc_resolve (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue,
   input  bbc_pkg::stage_type  stage_word,
   input  bbc_pkg::kind_type   rd_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output bbc_pkg::rsp_type    rsp_data,
   output logic                req_stall,
   output logic                string_err
);

   logic               b_valid_ff, b_valid_in;
   bbc_pkg::stage_type b_word_ff, b_word_in;
   logic               mis_ff, mis_in;
   logic               out_valid_ff, out_valid_in;
   bbc_pkg::rsp_type   out_data_ff, out_data_in;
   logic               mis_now, mis_all, out_free, b_done, load;

   always_comb begin
      mis_now  = b_valid_ff & b_word_ff.pop_check & (rd_data != b_word_ff.kind);
      mis_all  = mis_ff | mis_now;
      out_free = !out_valid_ff | !rsp_stall;
      b_done   = b_valid_ff & (!b_word_ff.last | out_free);
      load     = b_done & b_word_ff.last;

      req_stall = b_valid_ff & !b_done;
      // a word held here that closes its string belongs to the previous string
      string_err = b_valid_ff ? (!b_word_ff.last & mis_all) : mis_ff;

      b_valid_in = issue | (b_valid_ff & !b_done);
      b_word_in  = issue ? stage_word : b_word_ff;

      mis_in = mis_ff;
      if (b_done) begin
         mis_in = b_word_ff.last ? 1'b0 : mis_all;
      end

      out_valid_in = load | (out_valid_ff & rsp_stall);
      out_data_in  = out_data_ff;
      if (load) begin
         out_data_in = '{balanced:   !mis_all & !b_word_ff.error &
                                     b_word_ff.level_zero & b_word_ff.any_char,
                         overflowed: b_word_ff.overflow};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         mis_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         mis_ff       <= mis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_word_ff   <= b_word_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: hdl/bracket_balance_checker.sv
// Top level of the bracket balance checker.
//
// channel  dir  handshake              word
// req      in   req_valid / req_stall  bbc_pkg::req_type {char_code, no_char, last}
// rsp      out  rsp_valid / rsp_stall  bbc_pkg::rsp_type {balanced, overflowed}
//
// One request word enters per cycle while req_stall is low; the stack memory
// takes one push or one top read per word, and that single port pair sets the rate.
// A result passes from the back-stage word register into the output register.
// Reset clears the level, flags and pipeline valids; stack entries are left as
// they are, since an entry is read only below the current level.
// req_stall rises only while a finished result is held by rsp_stall and a
// further last word waits behind it.
module bracket_balance_checker #(
   parameter int unsigned DEPTH = bbc_pkg::BBC_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bbc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bbc_pkg::rsp_type  rsp_data
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic                issue;
   logic                string_err;
   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   bbc_pkg::kind_type   wr_data, rd_data;
   bbc_pkg::stage_type  stage_word;

   // take a word whenever the back stage is not holding a stalled result
   assign issue = req_valid & !req_stall;

   // Front: decode, track the level, push openers, issue top reads for closers.
   // Closers are resolved speculatively; a mismatch found in the following cycle
   // is fed back through string_err and freezes the rest of the string.
   bbc_track #(
      .DEPTH(DEPTH)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .req_data   (req_data),
      .string_err (string_err),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .stage_word (stage_word)
   );

   // Stack of open bracket kinds, addressed by level.
   bbc_stack_ram #(
      .DEPTH(DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Back: compare the read top with the closer, drop a string on mismatch,
   // and hold the result in the output register until it is taken.
   bbc_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .stage_word (stage_word),
      .rd_data    (rd_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .req_stall  (req_stall),
      .string_err (string_err)
   );

endmodule

FILE: hdl/bbc_checker.sv
// Port-level assertions for the bracket balance checker, bound to the top level.
`include "bracket_balance_checker_defines.svh"

module bbc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bbc_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bbc_pkg::rsp_type  rsp_data
);

   `BBC_ASSERT_NOW(a_ovf_not_balanced, clock, reset, rsp_valid, !(rsp_data.balanced && rsp_data.overflowed), "overflow reported with balanced set")

   `BBC_ASSERT_NOW(a_stall_only_on_held_result, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a held result")

   `BBC_ASSERT_NOW(a_result_after_last, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && req_data.last, 2), "result without a last word two cycles earlier")

   `BBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result dropped or changed")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: bench/bracket_result_checker.sv
// Checker that predicts and compares the verdicts of the bracket balance checker.
`timescale 1ns / 1ps

module bracket_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bbc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bbc_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               verdicts_pending
);
   import bbc_pkg::*;

   kind_type    open_kinds [BBC_DEPTH];
   int unsigned nest_level;
   logic        bad_close;
   logic        stack_spilled;
   logic        saw_char;
   rsp_type     expected_verdicts [$];
   int          mismatches = 0;
   int          waiting = 0;

   assign fail_count       = mismatches;
   assign verdicts_pending = waiting;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic clear_string();
      nest_level    = 0;
      bad_close     = 1'b0;
      stack_spilled = 1'b0;
      saw_char      = 1'b0;
   endtask

   task automatic push_open(input kind_type k);
      if (nest_level >= BBC_DEPTH) begin
         stack_spilled = 1'b1;
         bad_close     = 1'b1;
      end else begin
         open_kinds[nest_level] = k;
         nest_level++;
      end
   endtask

   task automatic pop_close(input kind_type k);
      if (nest_level == 0 || open_kinds[nest_level - 1] != k) begin
         bad_close = 1'b1;
      end else begin
         nest_level--;
      end
   endtask

   task automatic track_bracket_word(input req_type w);
      rsp_type verdict;
      if (!w.no_char) begin
         saw_char = 1'b1;
         if (!bad_close && !stack_spilled) begin
            case (w.char_code)
               CHAR_ROUND_OPEN:   push_open(KIND_ROUND);
               CHAR_SQUARE_OPEN:  push_open(KIND_SQUARE);
               CHAR_CURLY_OPEN:   push_open(KIND_CURLY);
               CHAR_ROUND_CLOSE:  pop_close(KIND_ROUND);
               CHAR_SQUARE_CLOSE: pop_close(KIND_SQUARE);
               CHAR_CURLY_CLOSE:  pop_close(KIND_CURLY);
               default: ;
            endcase
         end
      end
      if (w.last) begin
         verdict.balanced   = !bad_close && !stack_spilled && nest_level == 0 && saw_char;
         verdict.overflowed = stack_spilled;
         expected_verdicts.push_back(verdict);
         clear_string();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_string();
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result word with no verdict expected");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.balanced !== want.balanced)
                  report_mismatch($sformatf("balanced got %b want %b",
                                            rsp_data.balanced, want.balanced));
               if (rsp_data.overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed got %b want %b",
                                            rsp_data.overflowed, want.overflowed));
            end
         end
         if (req_valid && !req_stall)
            track_bracket_word(req_data);
      end
      waiting <= expected_verdicts.size();
   end

endmodule

FILE: bench/tb.sv
// Top of the bracket balance checker testbench: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb;
   import bbc_pkg::*;

   typedef logic [7:0] text_q [$];

   localparam int unsigned WORD_TARGET = 1200;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned TAIL_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int          fail_count;
   int          verdicts_pending;
   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   bit          hold_go     = 1'b0;
   bit          hold_done   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned words_sent  = 0;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   bracket_balance_checker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   bracket_result_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending)
   );

   // Count cycles for the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Receiver side: random stall at the current rate, or one long hold-off
   // counted here once the stimulus raises hold_go.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Abort a run that hangs.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic kind_type random_kind();
      return kind_type'($urandom_range(1, 3));
   endfunction

   function automatic logic [7:0] open_of(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_ROUND_OPEN;
         KIND_SQUARE: return CHAR_SQUARE_OPEN;
         default:     return CHAR_CURLY_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] close_of(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_ROUND_CLOSE;
         KIND_SQUARE: return CHAR_SQUARE_CLOSE;
         default:     return CHAR_CURLY_CLOSE;
      endcase
   endfunction

   // Any byte but a bracket; all bracket codes sit below 8'h80, so flipping
   // the top bit moves a bracket off the list without losing bit coverage.
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      if (c == CHAR_ROUND_OPEN || c == CHAR_ROUND_CLOSE || c == CHAR_SQUARE_OPEN ||
          c == CHAR_SQUARE_CLOSE || c == CHAR_CURLY_OPEN || c == CHAR_CURLY_CLOSE)
         c = c ^ 8'h80;
      return c;
   endfunction

   // Well-formed text: random nesting up to max_level with noise bytes mixed in,
   // every opener closed at the end.
   function automatic text_q make_nested(input int unsigned len, input int unsigned max_level);
      text_q       s;
      kind_type    opened [$];
      kind_type    k;
      int unsigned pick;
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 40 && opened.size() < max_level) begin
            k = random_kind();
            opened.push_back(k);
            s.push_back(open_of(k));
         end else if (pick < 75 && opened.size() > 0) begin
            s.push_back(close_of(opened.pop_back()));
         end else begin
            s.push_back(noise_char());
         end
      end
      while (opened.size() > 0)
         s.push_back(close_of(opened.pop_back()));
      return s;
   endfunction

   // Damage a well-formed text: drop a byte, insert a stray closer or opener,
   // or lead with a closer that meets an empty stack.
   function automatic text_q break_text(input text_q s);
      case ($urandom_range(3))
         0: if (s.size() > 0) s.delete($urandom_range(s.size() - 1));
         1: s.insert($urandom_range(s.size()), close_of(random_kind()));
         2: s.insert($urandom_range(s.size()), open_of(random_kind()));
         default: s.push_front(close_of(random_kind()));
      endcase
      return s;
   endfunction

   // Loose mix of random bytes and random brackets.
   function automatic text_q make_jumble(input int unsigned len);
      text_q s;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(1))
            s.push_back(8'($urandom_range(255)));
         else if ($urandom_range(1))
            s.push_back(open_of(random_kind()));
         else
            s.push_back(close_of(random_kind()));
      end
      return s;
   endfunction

   // Fill the stack to its full depth, or one past it, then unwind.
   function automatic text_q make_deep(input bit spill);
      text_q    s;
      kind_type opened [$];
      kind_type k;
      int unsigned n;
      n = spill ? BBC_DEPTH + 1 : BBC_DEPTH;
      for (int unsigned i = 0; i < n; i++) begin
         k = random_kind();
         opened.push_back(k);
         s.push_back(open_of(k));
      end
      while (opened.size() > 1)
         s.push_back(close_of(opened.pop_back()));
      if (!spill)
         s.push_back(close_of(opened.pop_back()));
      return s;
   endfunction

   // Offer one word after a random idle gap and hold it until accepted.
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Send one string; blank words may fall before any byte, and the string may
   // close on a blank word instead of its last byte.
   task automatic send_string(input text_q text, input int unsigned blank_pct,
                              input bit blank_end);
      req_type w;
      for (int i = 0; i < text.size(); i++) begin
         if ($urandom_range(99) < blank_pct) begin
            w = '{char_code: 8'($urandom_range(255)), no_char: 1'b1, last: 1'b0};
            send_word(w);
         end
         w = '{char_code: text[i], no_char: 1'b0,
               last: (i == text.size() - 1) && !blank_end};
         send_word(w);
      end
      if (blank_end || text.size() == 0) begin
         w = '{char_code: 8'($urandom_range(255)), no_char: 1'b1, last: 1'b1};
         send_word(w);
      end
   endtask

   task automatic send_random_string();
      text_q       s;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55)
         s = make_nested($urandom_range(1, 24), 16);
      else if (pick < 75)
         s = break_text(make_nested($urandom_range(1, 24), 16));
      else if (pick < 90)
         s = make_jumble($urandom_range(1, 12));
      else if (pick < 98)
         s.delete();
      else
         s = make_deep(1'($urandom_range(1)));
      send_string(s, 5, $urandom_range(99) < 10);
   endtask

   // Drop valid and hold off until every verdict has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      text_q   s;
      req_type w;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 0: no idling on either side; directed strings first.
      idle_pct  = 0;
      stall_pct = 0;

      // empty string, alone and behind blank words
      s.delete();
      send_string(s, 0, 1'b0);
      w = '{char_code: 8'hA5, no_char: 1'b1, last: 1'b0};
      send_word(w);
      send_string(s, 0, 1'b0);

      // every opener with its closer, then a nested set
      s = {CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE};
      send_string(s, 0, 1'b0);
      s = {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE};
      send_string(s, 0, 1'b0);
      s = {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE};
      send_string(s, 0, 1'b0);
      s = {CHAR_CURLY_OPEN, CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE, CHAR_CURLY_CLOSE};
      send_string(s, 0, 1'b0);

      // wrong kind closes, then later brackets are ignored
      s = {CHAR_ROUND_OPEN, CHAR_SQUARE_CLOSE, CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE};
      send_string(s, 0, 1'b0);

      // closer meets an empty stack
      s = {CHAR_ROUND_CLOSE};
      send_string(s, 0, 1'b0);

      // NUL and all-ones bytes count as ordinary characters
      s = {8'h00, 8'hFF};
      send_string(s, 0, 1'b0);

      // blank words between characters, and a string closed by a blank
      s = {CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE};
      send_string(s, 100, 1'b0);
      s = {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE};
      send_string(s, 0, 1'b1);

      // stack filled exactly, then one push past it
      send_string(make_deep(1'b0), 0, 1'b0);
      send_string(make_deep(1'b1), 0, 1'b0);

      while (words_sent < WORD_TARGET / 4)
         send_random_string();

      // Pause the sender until every verdict is home.
      wait_drained();

      // Phase 1: sender idles most cycles.
      idle_pct = 73;
      while (words_sent < WORD_TARGET / 2)
         send_random_string();

      // Phase 2: receiver stalls most cycles; start with one long hold-off
      // while short strings keep coming so the block fills and stalls input.
      idle_pct  = 0;
      stall_pct = 73;
      hold_go   = 1'b1;
      for (int i = 0; i < 40; i++)
         send_string(make_nested($urandom_range(1, 4), 2), 0, 1'b0);
      while (words_sent < 3 * WORD_TARGET / 4)
         send_random_string();

      // Phase 3: light idling on both sides.
      idle_pct  = 12;
      stall_pct = 12;
      while (words_sent < WORD_TARGET)
         send_random_string();

      // Drain, let the output register settle, then give the verdict.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && verdicts_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: bracket_balance_checker.f
+incdir+hdl
hdl/bbc_pkg.sv
hdl/bbc_stack_ram.sv
hdl/bbc_track.sv
hdl/bbc_resolve.sv
hdl/bracket_balance_checker.sv
hdl/bbc_checker.sv
bench/bracket_result_checker.sv
bench/tb.sv
